>>> rtl/dgpid_pkg.sv
// ----------------------------------------------------------------------------
// dgpid_pkg - shared constants for the dual-gain PID controller
// Register map, fixed widths and the fixed-point scaling constants.
// ----------------------------------------------------------------------------
package dgpid_pkg;

  // Default generics
  localparam int ERROR_WIDTH_DEF = 24;
  localparam int HOLD_PERIOD_DEF = 11;

  // Fixed field widths
  localparam int GAIN_W     = 32;
  localparam int LIMIT_W    = 20;
  localparam int ACC_W      = 48;
  localparam int OUT_W      = 48;
  localparam int CFG_ADDR_W = 3;

  // Register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ANGLE_KP     = 3'd0,
    REG_ANGLE_KI     = 3'd1,
    REG_ANGLE_KD     = 3'd2,
    REG_SPEED_KP     = 3'd3,
    REG_SPEED_KI     = 3'd4,
    REG_SPEED_KD     = 3'd5,
    REG_WINDUP_LIMIT = 3'd6
  } cfg_reg_t;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd1000;

  // Decimal divisor used by both the increment and the output scaling
  localparam int DEC_W = 10;
  localparam logic [DEC_W-1:0] DEC_BASE = 10'd1000;
  localparam int ROUND_HALF = 500;

  // Fraction shifts: 65536/1000 for speed, 65536/64000 = 1024/1000 for angle
  localparam int SPEED_SH = 16;
  localparam int ANGLE_SH = 10;

  // Reciprocal of 1000, exact for numerators below 2^26
  localparam int FRAC_N_W = 26;
  localparam int FRAC_SH  = 36;
  localparam int FRAC_M_W = 27;
  localparam logic [FRAC_M_W-1:0] FRAC_RCP = 27'd68719477;
  localparam int FRAC_P_W = FRAC_N_W + FRAC_M_W;

  // Output long division: radix 2^16 digits over a 64-bit magnitude
  localparam int DIG_W = 16;
  localparam int NDIG  = 4;
  localparam int DMAG_W = DIG_W * NDIG;

  // Saturation bounds
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  // Quotient reaches 2^47 once the magnitude reaches 1000 * 2^47
  localparam logic [DMAG_W-1:0] SAT_MAG = 64'(64'd1000 << (ACC_W - 1));

endpackage

>>> rtl/dual_gain_pid_with_clamped_integral.sv
// ----------------------------------------------------------------------------
// dual_gain_pid_with_clamped_integral - PID controller, two gain sets
// Fourteen-stage pipeline: increment scaling, accumulator update, products,
// integral clamp, sum and a radix-2^16 division by 1000 with saturation.
// ----------------------------------------------------------------------------
// Takes one error transaction per clock and returns one drive transaction per
// error, in order, when the output side is ready. The only feedback is the
// accumulator, held-error and tick-counter update in stage 4, so throughput is
// one item per clock unless back-pressure on the output side stalls the pipeline.
// Every stage has its own valid bit and stalls only when the stage behind it
// is full, so a waiting result does not hold up the input side until the
// pipeline is full. Configuration must be written while the pipeline is empty.
// ----------------------------------------------------------------------------
module dual_gain_pid_with_clamped_integral #(
  parameter int ERROR_WIDTH = dgpid_pkg::ERROR_WIDTH_DEF,
  parameter int HOLD_PERIOD = dgpid_pkg::HOLD_PERIOD_DEF
) (
  input  logic clk,
  input  logic rst,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [dgpid_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [dgpid_pkg::GAIN_W-1:0]      cfg_wdata,
  // Error stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((ERROR_WIDTH+8)/8)*8-1:0]       s_tdata,  // error_value, restart
  input  logic                                   s_tuser,  // loop_select
  // Drive stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [dgpid_pkg::OUT_W-1:0]            m_tdata   // drive_value
);

  localparam int EW      = ERROR_WIDTH;
  localparam int ACC_W   = dgpid_pkg::ACC_W;
  localparam int GAIN_W  = dgpid_pkg::GAIN_W;
  localparam int NDIG    = dgpid_pkg::NDIG;
  localparam int DIG_W   = dgpid_pkg::DIG_W;
  localparam int DMAG_W  = dgpid_pkg::DMAG_W;
  localparam int DEC_W   = dgpid_pkg::DEC_W;
  localparam int QUO_W   = dgpid_pkg::OUT_W;
  localparam int TICK_W  = $clog2(HOLD_PERIOD + 1);

  // Reciprocal of 1000 exact for EW-bit magnitudes
  localparam int RCP_SH  = EW + 10;
  localparam int RCP_P_W = 2 * EW + 11;
  localparam logic [EW:0] RCP_M = (EW+1)'(((64'd1 << RCP_SH) + 64'd999) / 64'd1000);

  // Datapath widths
  localparam int INC_W   = EW + 8;
  localparam int P_W     = EW + GAIN_W;
  localparam int D_W     = EW + GAIN_W + 1;
  localparam int I_W     = dgpid_pkg::LIMIT_W + 17;
  localparam int LIM_W   = dgpid_pkg::LIMIT_W + 16;
  localparam int SUM_W   = EW + 33;
  localparam int TMAG_W  = SUM_W - 1;

  // Stage numbering
  localparam int ST_IN   = 0;
  localparam int ST_RCP  = 1;
  localparam int ST_FRAC = 2;
  localparam int ST_INC  = 3;
  localparam int ST_ACC  = 4;
  localparam int ST_MUL  = 5;
  localparam int ST_INT  = 6;
  localparam int ST_SUM  = 7;
  localparam int ST_MAG  = 8;
  localparam int ST_OUT  = ST_MAG + NDIG + 1;
  localparam int NSTG    = ST_OUT + 1;

  // Configuration registers
  logic signed [GAIN_W-1:0] angle_kp, angle_ki, angle_kd;
  logic signed [GAIN_W-1:0] speed_kp, speed_ki, speed_kd;
  logic [dgpid_pkg::LIMIT_W-1:0] windup_limit;

  // Pipeline control
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  // Stage payloads
  logic signed [EW-1:0] err0, err1, err2, err3, err4;
  logic                 sel0, sel1, sel2, sel3, sel4;
  logic                 rst0, rst1, rst2, rst3;
  logic [EW-1:0]        mag1, quo1, quo2;
  logic                 neg1, neg2;
  logic [dgpid_pkg::FRAC_N_W-1:0] frac2;
  logic signed [INC_W-1:0] inc3;

  // Loop state
  logic signed [ACC_W-1:0] acc;
  logic signed [EW-1:0]    held_error;
  logic [TICK_W-1:0]       tick_count;
  logic signed [EW:0]      diff4;

  logic signed [P_W-1:0]   p5, p6;
  logic signed [D_W-1:0]   d5, d6;
  logic [47:0]             ph5;
  logic [63:0]             pl5;
  logic                    isgn5;
  logic signed [I_W-1:0]   i6;
  logic signed [SUM_W-1:0] sum7;

  // Division stages, index 0 is the magnitude stage
  logic [DMAG_W-1:0] dv_mag [NDIG+1];
  logic [DEC_W-1:0]  dv_rem [NDIG+1];
  logic [QUO_W-1:0]  dv_quo [NDIG+1];
  logic              dv_neg [NDIG+1];
  logic              dv_sat [NDIG+1];

  // ---------------- combinational signals ----------------
  logic [EW-1:0]          mag0;
  logic [RCP_P_W-1:0]     rcp_prod;
  logic [DEC_W-1:0]       rem1;
  logic [dgpid_pkg::FRAC_P_W-1:0] frac_prod;
  logic [16:0]            frac_q;
  logic [INC_W-1:0]       inc_mag;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [EW-1:0]    held_base;
  logic signed [EW:0]      diff_next;
  logic [TICK_W-1:0]       tick_inc;
  logic signed [GAIN_W-1:0] kp_sel, ki_sel, kd_sel;
  logic [GAIN_W-1:0]       ki_mag;
  logic [ACC_W-1:0]        acc_mag;
  logic [63:0]             im;
  logic [LIM_W-1:0]        lim;
  logic [LIM_W-1:0]        im_clip;
  logic [TMAG_W-1:0]       tmag;
  logic [dgpid_pkg::FRAC_N_W-1:0] dig_n    [NDIG];
  logic [dgpid_pkg::FRAC_P_W-1:0] dig_prod [NDIG];
  logic [DIG_W-1:0]               dig_q    [NDIG];
  logic [DEC_W-1:0]               dig_rem  [NDIG];
  logic [QUO_W-1:0]               drive_mag;

  assign s_tready = adv[ST_IN];
  assign m_tvalid = vld[ST_OUT];

  // Stall chain: a stage may load when it is empty or its successor moves
  always_comb begin
    adv[NSTG-1] = ~vld[NSTG-1] | m_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = ~vld[k] | adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_kp     <= '0;
      angle_ki     <= '0;
      angle_kd     <= '0;
      speed_kp     <= '0;
      speed_ki     <= '0;
      speed_kd     <= '0;
      windup_limit <= dgpid_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dgpid_pkg::REG_ANGLE_KP:     angle_kp     <= cfg_wdata;
        dgpid_pkg::REG_ANGLE_KI:     angle_ki     <= cfg_wdata;
        dgpid_pkg::REG_ANGLE_KD:     angle_kd     <= cfg_wdata;
        dgpid_pkg::REG_SPEED_KP:     speed_kp     <= cfg_wdata;
        dgpid_pkg::REG_SPEED_KI:     speed_ki     <= cfg_wdata;
        dgpid_pkg::REG_SPEED_KD:     speed_kd     <= cfg_wdata;
        dgpid_pkg::REG_WINDUP_LIMIT: windup_limit <= cfg_wdata[dgpid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: input register
  always_ff @(posedge clk) begin
    if (adv[ST_IN]) begin
      err0 <= s_tdata[EW-1:0];
      rst0 <= s_tdata[EW];
      sel0 <= s_tuser;
    end
  end

  // Stage 1: |err| / 1000 by reciprocal
  always_comb begin
    mag0     = err0[EW-1] ? EW'(-err0) : EW'(err0);
    rcp_prod = RCP_P_W'(mag0) * RCP_P_W'(RCP_M);
  end

  always_ff @(posedge clk) begin
    if (adv[ST_RCP]) begin
      mag1 <= mag0;
      quo1 <= rcp_prod[RCP_SH +: EW];
      neg1 <= err0[EW-1];
      err1 <= err0;
      sel1 <= sel0;
      rst1 <= rst0;
    end
  end

  // Stage 2: remainder, scaled and offset for rounding
  always_comb begin
    rem1 = DEC_W'((EW+DEC_W)'(mag1) - (EW+DEC_W)'(quo1) * (EW+DEC_W)'(dgpid_pkg::DEC_BASE));
  end

  always_ff @(posedge clk) begin
    if (adv[ST_FRAC]) begin
      frac2 <= (sel1 ? (dgpid_pkg::FRAC_N_W'(rem1) << dgpid_pkg::ANGLE_SH)
                     : (dgpid_pkg::FRAC_N_W'(rem1) << dgpid_pkg::SPEED_SH))
             + dgpid_pkg::FRAC_N_W'(dgpid_pkg::ROUND_HALF);
      quo2  <= quo1;
      neg2  <= neg1;
      err2  <= err1;
      sel2  <= sel1;
      rst2  <= rst1;
    end
  end

  // Stage 3: rounded increment = quo * 2^sh + round(frac / 1000)
  always_comb begin
    frac_prod = dgpid_pkg::FRAC_P_W'(frac2) * dgpid_pkg::FRAC_P_W'(dgpid_pkg::FRAC_RCP);
    frac_q    = frac_prod[dgpid_pkg::FRAC_SH +: 17];
    inc_mag   = (sel2 ? (INC_W'(quo2) << dgpid_pkg::ANGLE_SH)
                      : (INC_W'(quo2) << dgpid_pkg::SPEED_SH)) + INC_W'(frac_q);
  end

  always_ff @(posedge clk) begin
    if (adv[ST_INC]) begin
      inc3 <= neg2 ? -inc_mag : inc_mag;
      err3 <= err2;
      sel3 <= sel2;
      rst3 <= rst2;
    end
  end

  // Stage 4: accumulator, held error and tick counter
  always_comb begin
    acc_base  = rst3 ? '0 : acc;
    held_base = rst3 ? '0 : held_error;
    acc_sum   = (ACC_W+1)'(acc_base) + (ACC_W+1)'(inc3);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_next = acc_sum[ACC_W] ? dgpid_pkg::ACC_MIN : dgpid_pkg::ACC_MAX;
    end else begin
      acc_next = acc_sum[ACC_W-1:0];
    end
    diff_next = (EW+1)'(err3) - (EW+1)'(held_base);
    tick_inc  = tick_count + TICK_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      held_error <= '0;
      tick_count <= '0;
    end else if (adv[ST_ACC] && vld[ST_INC]) begin
      acc <= acc_next;
      if (tick_inc >= TICK_W'(HOLD_PERIOD)) begin
        held_error <= err3;
        tick_count <= '0;
      end else begin
        held_error <= held_base;
        tick_count <= tick_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_ACC]) begin
      diff4 <= diff_next;
      err4  <= err3;
      sel4  <= sel3;
    end
  end

  // Stage 5: gain products; |Ki|*|acc| split into high and low partials
  always_comb begin
    kp_sel  = sel4 ? angle_kp : speed_kp;
    ki_sel  = sel4 ? angle_ki : speed_ki;
    kd_sel  = sel4 ? angle_kd : speed_kd;
    ki_mag  = ki_sel[GAIN_W-1] ? GAIN_W'(-ki_sel) : GAIN_W'(ki_sel);
    acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  end

  always_ff @(posedge clk) begin
    if (adv[ST_MUL]) begin
      p5    <= P_W'(kp_sel) * P_W'(err4);
      d5    <= D_W'(kd_sel) * D_W'(diff4);
      ph5   <= 48'(ki_mag) * 48'(acc_mag[ACC_W-1:32]);
      pl5   <= 64'(ki_mag) * 64'(acc_mag[31:0]);
      isgn5 <= ki_sel[GAIN_W-1] ^ acc[ACC_W-1];
    end
  end

  // Stage 6: integral magnitude >> 16, clamp to the windup limit
  always_comb begin
    im      = {ph5, 16'd0} + 64'(pl5[63:16]);
    lim     = {windup_limit, 16'd0};
    im_clip = (im > 64'(lim)) ? lim : im[LIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[ST_INT]) begin
      i6 <= isgn5 ? -(I_W'(im_clip)) : I_W'(im_clip);
      p6 <= p5;
      d6 <= d5;
    end
  end

  // Stage 7: P + I + D
  always_ff @(posedge clk) begin
    if (adv[ST_SUM]) begin
      sum7 <= SUM_W'(p6) + SUM_W'(i6) + SUM_W'(d6);
    end
  end

  // Stage 8: sign, magnitude and saturation check
  always_comb begin
    tmag = sum7[SUM_W-1] ? TMAG_W'(-sum7) : TMAG_W'(sum7);
  end

  // Stages 9..12: one radix-2^16 quotient digit per stage
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      dig_n[d]    = {dv_rem[d], dv_mag[d][DMAG_W-1-d*DIG_W -: DIG_W]};
      dig_prod[d] = dgpid_pkg::FRAC_P_W'(dig_n[d])
                  * dgpid_pkg::FRAC_P_W'(dgpid_pkg::FRAC_RCP);
      dig_q[d]    = dig_prod[d][dgpid_pkg::FRAC_SH +: DIG_W];
      dig_rem[d]  = DEC_W'(dig_n[d] - dgpid_pkg::FRAC_N_W'(dig_q[d])
                  * dgpid_pkg::FRAC_N_W'(dgpid_pkg::DEC_BASE));
    end
  end

  // Division registers: stage 8 load, then one digit shifted in per stage
  always_ff @(posedge clk) begin
    if (adv[ST_MAG]) begin
      dv_mag[0] <= DMAG_W'(tmag);
      dv_rem[0] <= '0;
      dv_quo[0] <= '0;
      dv_neg[0] <= sum7[SUM_W-1];
      dv_sat[0] <= DMAG_W'(tmag) >= dgpid_pkg::SAT_MAG;
    end
    for (int d = 0; d < NDIG; d++) begin
      if (adv[ST_MAG + 1 + d]) begin
        dv_mag[d+1] <= dv_mag[d];
        dv_rem[d+1] <= dig_rem[d];
        dv_quo[d+1] <= {dv_quo[d][QUO_W-DIG_W-1:0], dig_q[d]};
        dv_neg[d+1] <= dv_neg[d];
        dv_sat[d+1] <= dv_sat[d];
      end
    end
  end

  // Stage 13: apply sign and saturation into the output register
  assign drive_mag = dv_quo[NDIG];

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      if (dv_sat[NDIG]) begin
        m_tdata <= dv_neg[NDIG] ? dgpid_pkg::ACC_MIN : dgpid_pkg::ACC_MAX;
      end else begin
        m_tdata <= dv_neg[NDIG] ? -drive_mag : drive_mag;
      end
    end
  end

endmodule

>>> bench/dual_gain_pid_with_clamped_integral_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_gain_pid_with_clamped_integral_tb - self-checking bench for the PID
// A short directed table (reset values, extreme gains, restart, zero windup
// limit, unmapped register write) is followed by random error streams under
// several gain settings and idle patterns, with one long output hold-off that
// fills the pipeline. Every drive transaction is compared against a typed value
// from the table or an in-bench model of the controller.
// ----------------------------------------------------------------------------
module dual_gain_pid_with_clamped_integral_tb;

  localparam int CFG_ADDR_W  = dgpid_pkg::CFG_ADDR_W;
  localparam int GAIN_W      = dgpid_pkg::GAIN_W;
  localparam int LIMIT_W     = dgpid_pkg::LIMIT_W;
  localparam int ACC_W       = dgpid_pkg::ACC_W;
  localparam int OUT_W       = dgpid_pkg::OUT_W;
  localparam int ERR_W       = dgpid_pkg::ERROR_WIDTH_DEF;
  localparam int TDATA_W     = ((ERR_W + 8) / 8) * 8;
  localparam int HOLD        = dgpid_pkg::HOLD_PERIOD_DEF;
  localparam int PHASE_ITEMS = 267;
  localparam int STALL_CYCLES = 64;
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [CFG_ADDR_W-1:0]       addr;
    logic [GAIN_W-1:0]           data;
    logic signed [ERR_W-1:0]     err;
    logic                        angle;
    logic                        restart;
    logic                        typed;
    logic signed [OUT_W-1:0]     want;
  } plan_row_t;

  // DUT ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [GAIN_W-1:0]      cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_W-1:0]     s_tdata = '0;  // error_value, restart
  logic                   s_tuser = 1'b0;  // loop_select
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_W-1:0]       m_tdata;  // drive_value

  // Controller model: configuration and state
  logic signed [GAIN_W-1:0]  ang_kp = '0, ang_ki = '0, ang_kd = '0;
  logic signed [GAIN_W-1:0]  spd_kp = '0, spd_ki = '0, spd_kd = '0;
  logic [LIMIT_W-1:0]        windup = dgpid_pkg::LIMIT_RESET;
  logic signed [ACC_W-1:0]   acc_state = '0;
  logic signed [ERR_W-1:0]   held_err = '0;
  logic [3:0]                tick_cnt = '0;

  logic [OUT_W-1:0] drive_q[$];
  logic [OUT_W-1:0] drive_want;
  plan_row_t        plan_q[$];
  int               fail_cnt = 0;
  int               send_idle_pct = 35;
  int               recv_idle_pct = 85;
  bit               stall_req = 1'b0;

  dual_gain_pid_with_clamped_integral u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #6 clk = ~clk;

  // Run-away guard
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // One controller step: updates the model state, returns the drive value
  function automatic logic [OUT_W-1:0] next_drive(logic signed [ERR_W-1:0] err,
                                                  logic angle, logic restart);
    logic signed [127:0] e, div, q, acc_w, kp, ki, kd, p, d, prod, im, lim, total;
    if (restart) begin
      acc_state = '0;
      held_err  = '0;
    end
    e = err;
    // rounded increment, ties away from zero
    div = angle ? 64000 : 1000;
    q = ((e < 0 ? -e : e) * 65536 + div / 2) / div;
    acc_w = acc_state + (e < 0 ? -q : q);
    if (acc_w > dgpid_pkg::ACC_MAX) acc_w = dgpid_pkg::ACC_MAX;
    if (acc_w < dgpid_pkg::ACC_MIN) acc_w = dgpid_pkg::ACC_MIN;
    acc_state = acc_w[ACC_W-1:0];
    kp = angle ? ang_kp : spd_kp;
    ki = angle ? ang_ki : spd_ki;
    kd = angle ? ang_kd : spd_kd;
    p = kp * e;
    d = kd * (e - held_err);
    // integral magnitude truncated, then clamped to the windup limit
    prod = ki * acc_state;
    im = (prod < 0 ? -prod : prod) >>> 16;
    lim = windup;
    lim = lim <<< 16;
    if (im > lim) im = lim;
    total = p + (prod < 0 ? -im : im) + d;
    q = total / 1000;
    if (q > dgpid_pkg::ACC_MAX) q = dgpid_pkg::ACC_MAX;
    if (q < dgpid_pkg::ACC_MIN) q = dgpid_pkg::ACC_MIN;
    tick_cnt = tick_cnt + 4'd1;
    if (tick_cnt >= HOLD) begin
      held_err = err;
      tick_cnt = '0;
    end
    return q[OUT_W-1:0];
  endfunction

  function automatic void row_cfg(logic [CFG_ADDR_W-1:0] addr, logic [GAIN_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.addr = addr;
    r.data = data;
    plan_q.push_back(r);
  endfunction

  function automatic void row_item(logic signed [ERR_W-1:0] err, logic angle,
                                   logic restart, logic typed,
                                   logic signed [OUT_W-1:0] want);
    plan_row_t r;
    r = '0;
    r.kind    = ROW_ITEM;
    r.err     = err;
    r.angle   = angle;
    r.restart = restart;
    r.typed   = typed;
    r.want    = want;
    plan_q.push_back(r);
  endfunction

  // Gain with a random magnitude scale and sign
  function automatic logic [GAIN_W-1:0] gain_rand();
    logic [GAIN_W-1:0] g;
    g = $urandom >> $urandom_range(31);
    if ($urandom_range(1)) g = -g;
    return g;
  endfunction

  function automatic logic signed [ERR_W-1:0] error_rand();
    case ($urandom_range(7))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2, 3:    return 24'($urandom_range(2047)) - 24'd1024;
      default: return 24'($urandom);
    endcase
  endfunction

  // Register write, only once every outstanding drive value is back
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [GAIN_W-1:0] data);
    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      dgpid_pkg::REG_ANGLE_KP:     ang_kp = data;
      dgpid_pkg::REG_ANGLE_KI:     ang_ki = data;
      dgpid_pkg::REG_ANGLE_KD:     ang_kd = data;
      dgpid_pkg::REG_SPEED_KP:     spd_kp = data;
      dgpid_pkg::REG_SPEED_KI:     spd_ki = data;
      dgpid_pkg::REG_SPEED_KD:     spd_kd = data;
      dgpid_pkg::REG_WINDUP_LIMIT: windup = data[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one error transaction; called and left at a falling edge
  task automatic send_item(input logic signed [ERR_W-1:0] err, input logic angle,
                           input logic restart, input logic typed,
                           input logic signed [OUT_W-1:0] want);
    logic [OUT_W-1:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W-ERR_W-1){1'b0}}, restart, err};
    s_tuser  <= angle;
    do @(posedge clk); while (s_tready !== 1'b1);
    pred = next_drive(err, angle, restart);
    drive_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (stall_req) begin
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        stall_req = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drive checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (drive_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected drive transaction: expected none, actual %0d",
                 $time, $signed(m_tdata));
      end else begin
        drive_want = drive_q.pop_front();
        if (m_tdata !== drive_want) begin
          fail_cnt++;
          $display("%0t: drive_value mismatch: expected %0d, actual %0d",
                   $time, $signed(drive_want), $signed(m_tdata));
        end
      end
    end
  end

  initial begin : stimulus
    logic [GAIN_W-1:0] g[6];
    logic [LIMIT_W-1:0] lim;
    plan_row_t r;

    // Reset gains are zero, so the response is zero whatever the error
    row_item(24'sh000000, 1'b0, 1'b0, 1'b1, '0);
    row_item(24'sh7FFFFF, 1'b1, 1'b0, 1'b1, '0);
    row_item(24'sh800000, 1'b0, 1'b0, 1'b1, '0);
    row_item(-24'sd1,     1'b1, 1'b1, 1'b1, '0);
    // Unity proportional gain: output is error/1000 in Q.16
    row_cfg(dgpid_pkg::REG_SPEED_KP, 32'h0001_0000);
    row_item(24'sd1000,   1'b0, 1'b0, 1'b1, 48'sd65536);
    row_item(24'sh800000, 1'b0, 1'b0, 1'b1, -48'sd549755813);
    // Extreme gains on both loops, widest windup limit
    row_cfg(dgpid_pkg::REG_ANGLE_KP, 32'h7FFF_FFFF);
    row_cfg(dgpid_pkg::REG_ANGLE_KI, 32'h8000_0000);
    row_cfg(dgpid_pkg::REG_ANGLE_KD, 32'h0001_0000);
    row_cfg(dgpid_pkg::REG_SPEED_KP, 32'h8000_0000);
    row_cfg(dgpid_pkg::REG_SPEED_KI, 32'h7FFF_FFFF);
    row_cfg(dgpid_pkg::REG_SPEED_KD, 32'h7FFF_FFFF);
    row_cfg(dgpid_pkg::REG_WINDUP_LIMIT, 32'h000F_FFFF);
    // unmapped index must leave every register alone
    row_cfg(REG_UNMAPPED, 32'hFFFF_FFFF);
    row_item(24'sh7FFFFF, 1'b0, 1'b0, 1'b0, '0);
    row_item(24'sh800000, 1'b0, 1'b0, 1'b0, '0);
    row_item(24'sh7FFFFF, 1'b1, 1'b0, 1'b0, '0);
    row_item(24'sh800000, 1'b1, 1'b0, 1'b0, '0);
    row_item(24'sh000000, 1'b0, 1'b1, 1'b0, '0);
    row_item(24'sd1,      1'b0, 1'b0, 1'b0, '0);
    row_item(-24'sd1,     1'b1, 1'b0, 1'b0, '0);
    // held error was refreshed at the restart row above, then restart drops it again
    row_item(24'sh800000, 1'b0, 1'b0, 1'b0, '0);
    row_item(24'sh7FFFFF, 1'b1, 1'b1, 1'b0, '0);
    row_item(24'sh800000, 1'b0, 1'b0, 1'b0, '0);
    // Zero windup limit removes the integral term
    row_cfg(dgpid_pkg::REG_WINDUP_LIMIT, 32'h0000_0000);
    row_item(24'sh7FFFFF, 1'b0, 1'b0, 1'b0, '0);
    row_item(24'sh800000, 1'b1, 1'b0, 1'b0, '0);
    row_item(24'sh012345, 1'b0, 1'b1, 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int n = 0; n < plan_q.size(); n++) begin
      r = plan_q[n];
      if (r.kind == ROW_CFG) cfg_write(r.addr, r.data);
      else send_item(r.err, r.angle, r.restart, r.typed, r.want);
    end

    // Random streams under changing gains and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 85;
        recv_idle_pct = 35;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        1: begin
          foreach (g[k]) g[k] = 32'h7FFF_FFFF;
          lim = '1;
        end
        3: begin
          foreach (g[k]) g[k] = 32'h8000_0000;
          lim = '0;
        end
        default: begin
          foreach (g[k]) g[k] = gain_rand();
          lim = 20'($urandom_range(20'hFFFFF) >> $urandom_range(19));
        end
      endcase
      cfg_write(dgpid_pkg::REG_ANGLE_KP, g[0]);
      cfg_write(dgpid_pkg::REG_ANGLE_KI, g[1]);
      cfg_write(dgpid_pkg::REG_ANGLE_KD, g[2]);
      cfg_write(dgpid_pkg::REG_SPEED_KP, g[3]);
      cfg_write(dgpid_pkg::REG_SPEED_KI, g[4]);
      cfg_write(dgpid_pkg::REG_SPEED_KD, g[5]);
      cfg_write(dgpid_pkg::REG_WINDUP_LIMIT, {12'd0, lim});
      // long output hold-off while errors keep coming: pipeline fills up
      if (ph == 4) stall_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(error_rand(), 1'(($urandom_range(1))), ($urandom_range(24) == 0),
                  1'b0, '0);
    end

    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
